// ===== hw/rtl/cds_pkg.sv =====
package cds_pkg;

    // date limits
    localparam int YEAR_MIN  = 1900;
    localparam int YEAR_MAX  = 9999;
    localparam int COUNT_MAX = 255;

    // centuries divisor used by the leap-year tracking
    localparam int CENTURY = 100;

    // year 1900 split into year mod 100 and (year div 100) mod 4
    localparam logic [6:0] RESET_R100 = 7'(YEAR_MIN % CENTURY);
    localparam logic [1:0] RESET_Q4   = 2'((YEAR_MIN / CENTURY) % 4);

    // command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_FWD  = 2'd0,
        CMD_BACK = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    // leap rule from year mod 4, year mod 100 and (year div 100) mod 4
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] r100,
                                     input logic [1:0] q4);
        logic div100;
        div100 = (r100 == 7'd0);
        return (!div100 && (y_lo == 2'd0)) || (div100 && (q4 == 2'd0));
    endfunction

    // days in a month, month 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/calendar_date_stepper.sv =====
// Gregorian date stepper.
// Holds a date starting at 1 January 1900. Each input beat carries a command
// in s_axis_tuser (forward, backward, load) and its operands in s_axis_tdata.
// Every input beat produces exactly one output beat with the date after the
// command, a load_ok flag and an at_floor flag.
// Sequencing: a step command walks the date one day per cycle, then passes
// the date to the output register; a load takes the century count of the year
// by a reciprocal multiply, then the year mod 100, then a check step; an unused
// command goes straight to the output register. The block takes one command
// at a time; s_axis_tready is high only while it is idle.
// A finished result sits in the output register until taken, and the next
// command may be accepted meanwhile; if the receiver stalls, the sequencer
// holds its second result until the output register frees up.
// Reset (rst_n, asynchronous, active low) returns the date to 1 January 1900
// and empties the output register.
module calendar_date_stepper
    import cds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // day_count[7:0], day_in[12:8], month_in[16:13],
                                        // year_in[30:17], zero fill
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // day[4:0], month[8:5], year[22:9], load_ok[23],
                                        // at_floor[24], zero fill
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_REM,
        ST_CHECK,
        ST_DONE
    } state_t;

    localparam logic [13:0] YMIN14 = 14'(YEAR_MIN);
    localparam logic [13:0] YMAX14 = 14'(YEAR_MAX);
    localparam logic [13:0] CENT14 = 14'(CENTURY);
    localparam logic [6:0]  CENT_M1 = 7'(CENTURY - 1);
    // ceil(2^19 / 100), exact floor of year / 100 for any 14-bit year
    localparam logic [12:0] RECIP100 = 13'd5243;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [4:0]  ld_day_reg, ld_day_next;
    logic [3:0]  ld_month_reg, ld_month_next;
    logic [13:0] ld_year_reg, ld_year_next;
    logic [7:0]  quot_reg, quot_next;
    logic [6:0]  rem_reg, rem_next;
    logic [1:0]  quo_reg, quo_next;
    logic        ok_reg, ok_next;

    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  r100_reg, r100_next;
    logic [1:0]  q4_reg, q4_next;

    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;

    logic        cur_leap;
    logic [4:0]  cur_len;
    logic [7:0]  quot_calc;
    logic [13:0] quot_x100;
    logic        ld_leap;
    logic        ld_valid;
    logic [15:0] cnt_wide;
    logic        at_floor;

    // input field unpacking
    logic [7:0]  in_count;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;

    assign in_count = s_axis_tdata[7:0];
    assign in_day   = s_axis_tdata[12:8];
    assign in_month = s_axis_tdata[16:13];
    assign in_year  = s_axis_tdata[30:17];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    // leap state of the current date and of the date being loaded
    assign cur_leap = is_leap(year_reg[1:0], r100_reg, q4_reg);
    assign cur_len  = month_len(month_reg, cur_leap);
    assign ld_leap  = is_leap(ld_year_reg[1:0], rem_reg, quo_reg);
    assign ld_valid = (ld_year_reg >= YMIN14) && (ld_year_reg <= YMAX14) &&
                      (ld_month_reg >= 4'd1) && (ld_month_reg <= 4'd12) &&
                      (ld_day_reg >= 5'd1) &&
                      (ld_day_reg <= month_len(ld_month_reg, ld_leap));

    // year / 100 by reciprocal multiply, and the quotient scaled back
    assign quot_calc = 8'(({13'd0, ld_year_reg} * {14'd0, RECIP100}) >> 19);
    assign quot_x100 = {6'd0, quot_reg} * CENT14;

    assign cnt_wide = {8'd0, in_count};
    assign at_floor = (day_reg == 5'd1) && (month_reg == 4'd1) && (year_reg == YMIN14);

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cnt_next      = cnt_reg;
        ld_day_next   = ld_day_reg;
        ld_month_next = ld_month_reg;
        ld_year_next  = ld_year_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        ok_next       = ok_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        r100_next     = r100_reg;
        q4_next       = q4_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;

        // output beat taken
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next      = cmd_t'(s_axis_tuser);
                    cnt_next      = (cnt_wide > 16'(COUNT_MAX)) ? 8'(COUNT_MAX) : in_count;
                    ld_day_next   = in_day;
                    ld_month_next = in_month;
                    ld_year_next  = in_year;
                    rem_next      = 7'd0;
                    quo_next      = 2'd0;
                    ok_next       = 1'b0;
                    case (cmd_t'(s_axis_tuser))
                        CMD_FWD:  state_next = ST_STEP;
                        CMD_BACK: state_next = ST_STEP;
                        CMD_LOAD: state_next = ST_DIV;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end

            // one day per cycle
            ST_STEP:
            begin
                if (cnt_reg == 8'd0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 8'd1;
                    if (cmd_reg == CMD_FWD)
                    begin
                        if (!((year_reg >= YMAX14) && (month_reg == 4'd12) &&
                              (day_reg == 5'd31)))
                        begin
                            if (day_reg < cur_len)
                            begin
                                day_next = day_reg + 5'd1;
                            end
                            else
                            begin
                                day_next = 5'd1;
                                if (month_reg == 4'd12)
                                begin
                                    month_next = 4'd1;
                                    year_next  = year_reg + 14'd1;
                                    if (r100_reg == CENT_M1)
                                    begin
                                        r100_next = 7'd0;
                                        q4_next   = q4_reg + 2'd1;
                                    end
                                    else
                                    begin
                                        r100_next = r100_reg + 7'd1;
                                    end
                                end
                                else
                                begin
                                    month_next = month_reg + 4'd1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (!at_floor)
                        begin
                            if (day_reg > 5'd1)
                            begin
                                day_next = day_reg - 5'd1;
                            end
                            else if (month_reg == 4'd1)
                            begin
                                month_next = 4'd12;
                                day_next   = 5'd31;
                                year_next  = year_reg - 14'd1;
                                if (r100_reg == 7'd0)
                                begin
                                    r100_next = CENT_M1;
                                    q4_next   = q4_reg - 2'd1;
                                end
                                else
                                begin
                                    r100_next = r100_reg - 7'd1;
                                end
                            end
                            else
                            begin
                                month_next = month_reg - 4'd1;
                                day_next   = month_len(month_reg - 4'd1, cur_leap);
                            end
                        end
                    end
                end
            end

            // century count of the load year
            ST_DIV:
            begin
                quot_next  = quot_calc;
                state_next = ST_REM;
            end

            // year mod 100 and century count mod 4
            ST_REM:
            begin
                rem_next   = 7'(ld_year_reg - quot_x100);
                quo_next   = quot_reg[1:0];
                state_next = ST_CHECK;
            end

            // validate and apply the load
            ST_CHECK:
            begin
                if (ld_valid)
                begin
                    day_next   = ld_day_reg;
                    month_next = ld_month_reg;
                    year_next  = ld_year_reg;
                    r100_next  = rem_reg;
                    q4_next    = quo_reg;
                    ok_next    = 1'b1;
                end
                state_next = ST_DONE;
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {7'd0, at_floor, ok_reg, year_reg, month_reg, day_reg};
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            day_reg    <= 5'd1;
            month_reg  <= 4'd1;
            year_reg   <= YMIN14;
            r100_reg   <= RESET_R100;
            q4_reg     <= RESET_Q4;
            cmd_reg    <= CMD_NOP;
            cnt_reg    <= 8'd0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            r100_reg   <= r100_next;
            q4_reg     <= q4_next;
            cmd_reg    <= cmd_next;
            cnt_reg    <= cnt_next;
            ok_reg     <= ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ld_day_reg   <= ld_day_next;
        ld_month_reg <= ld_month_next;
        ld_year_reg  <= ld_year_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        odata_reg    <= odata_next;
    end

endmodule
